[hw/rtl/tts_pkg.sv]
// Shared types and codes for the task timer scheduler.
package tts_pkg;
   typedef enum logic [2:0] {
      OP_REGISTER   = 3'd0,
      OP_DEREGISTER = 3'd1,
      OP_SCHEDULE   = 3'd2,
      OP_RESCHEDULE = 3'd3,
      OP_UNSCHEDULE = 3'd4,
      OP_TICK       = 3'd5,
      OP_SCAN       = 3'd6,
      OP_NOP        = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOFREE   = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [15:0] task_id;
      logic [31:0] delay;
      logic        periodic;
   } req_type;

   typedef struct packed {
      logic        fired;
      logic [15:0] fired_id;
      logic [1:0]  status;
      logic [31:0] clock_now;
      logic [31:0] run_total;
   } rsp_type;

   // Command a cell sees in the apply cycle.
   typedef struct packed {
      logic        clear;     // wipe slot
      logic        alloc;     // allocate with id
      logic        sched;     // new delay, deadline and flags
      logic        resched;   // deadline from stored delay, set flag
      logic        unsched;
      logic        fire;      // clear flag, re-arm if periodic
      logic [15:0] task_id;
      logic [31:0] delay;
      logic        periodic;
      logic [31:0] now;
   } cell_cmd_type;

   // Status a cell reports.
   typedef struct packed {
      logic        alloc;
      logic        sched;
      logic        due;
      logic [15:0] task_id;
   } cell_stat_type;
endpackage

[hw/rtl/tts_if.sv]
// Valid/ready channel interfaces for requests, responses and configuration.
interface tts_req_if;
   import tts_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tts_rsp_if;
   import tts_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tts_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/tts_cell.sv]
// One task slot: id, deadline, delay, flags and its due compare.
module tts_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   sel,
   input  tts_pkg::cell_cmd_type  cmd,
   input  logic [15:0]            match_id,
   output logic                   match,
   output tts_pkg::cell_stat_type stat
);
   import tts_pkg::*;

   logic [15:0] id_ff;
   logic [31:0] deadline_ff, delay_ff;
   logic        alloc_ff, sched_ff, periodic_ff;
   logic        due_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff    <= 1'b0;
         sched_ff    <= 1'b0;
         periodic_ff <= 1'b0;
         id_ff       <= '0;
         deadline_ff <= '0;
         delay_ff    <= '0;
      end else if (cmd.clear) begin
         alloc_ff    <= 1'b0;
         sched_ff    <= 1'b0;
         periodic_ff <= 1'b0;
         id_ff       <= '0;
         deadline_ff <= '0;
         delay_ff    <= '0;
      end else if (sel) begin
         if (cmd.alloc) begin
            alloc_ff    <= 1'b1;
            sched_ff    <= 1'b0;
            periodic_ff <= 1'b0;
            id_ff       <= cmd.task_id;
            deadline_ff <= '0;
            delay_ff    <= '0;
         end else if (cmd.sched) begin
            sched_ff    <= 1'b1;
            periodic_ff <= cmd.periodic;
            delay_ff    <= cmd.delay;
            deadline_ff <= cmd.now + cmd.delay;
         end else if (cmd.resched) begin
            sched_ff    <= 1'b1;
            deadline_ff <= cmd.now + delay_ff;
         end else if (cmd.unsched) begin
            sched_ff    <= 1'b0;
            deadline_ff <= '0;
         end else if (cmd.fire) begin
            sched_ff <= periodic_ff;
            if (periodic_ff) deadline_ff <= cmd.now + delay_ff;
         end
      end
   end

   // Registered due compare, refreshed each cycle.
   always_ff @(posedge clock) begin
      due_ff <= (cmd.now >= deadline_ff);
   end

   assign match         = alloc_ff && (id_ff == match_id);
   assign stat.alloc    = alloc_ff;
   assign stat.sched    = sched_ff;
   assign stat.due      = due_ff;
   assign stat.task_id  = id_ff;
endmodule

[hw/rtl/task_timer_scheduler.sv]
// Top level of the task timer scheduler: cell row, ring links and sequencer.
//
//  channel | dir | payload                                      | accept
//  req_    | in  | opcode, task_id, delay, periodic             | valid && ready
//  rsp_    | out | fired, fired_id, status, clock_now, run_total| valid && ready
//  csr_    | in  | active_slots (5 bits)                        | valid && ready
//
// A request passes from accept to response through decode (match and
// free search across the cell row, due compares settle), apply, respond.
// One request is in flight at a time; the next is taken only once the
// response register is free again and the sequencer is back in idle.
// Reset is synchronous and clears all slots, the ring, clock and run count.
// A stalled response holds its register. A csr write re-initializes the
// table and the ring.
module task_timer_scheduler #(
   parameter int MAX_SLOTS = 16
) (
   input logic clock,
   input logic reset,
   tts_req_if.sink   req,
   tts_rsp_if.source rsp,
   tts_csr_if.sink   csr
);
   import tts_pkg::*;

   localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CW = $clog2(MAX_SLOTS + 1);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_EVAL  = 3'b010,
      S_APPLY = 3'b100
   } state_type;

   state_type     state_ff, state_in;
   req_type       req_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;
   logic [CW-1:0] active_ff;
   logic [31:0]   clock_ff, runs_ff;
   logic [IW-1:0] next_ff [MAX_SLOTS];
   logic [IW-1:0] prev_ff [MAX_SLOTS];
   logic [IW-1:0] head_ff, tail_ff, cursor_ff;
   logic          ring_valid_ff, cursor_valid_ff;

   cell_cmd_type  cmd;
   cell_stat_type stat [MAX_SLOTS];
   logic [MAX_SLOTS-1:0] match, sel;

   // Decode results, registered at end of S_EVAL.
   logic          hit_ff, free_ok_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff;
   logic          hit_in, free_ok_in;
   logic [IW-1:0] hit_idx_in, free_idx_in;
   logic [IW-1:0] scan_idx;

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   // Lowest matching and lowest free slot within the active range.
   always_comb begin
      hit_in = 1'b0; free_ok_in = 1'b0;
      hit_idx_in = '0; free_idx_in = '0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         if (CW'(i) < active_ff) begin
            if (match[i]) begin hit_in = 1'b1; hit_idx_in = IW'(i); end
            if (!stat[i].alloc) begin free_ok_in = 1'b1; free_idx_in = IW'(i); end
         end
      end
   end

   assign scan_idx = cursor_valid_ff ? cursor_ff : head_ff;

   // Cell commands, only asserted in S_APPLY, but for the clear of a csr write.
   logic apply, do_op;
   logic [IW-1:0] tgt;
   assign apply = (state_ff == S_APPLY);
   always_comb begin
      opcode_type op;
      op = opcode_type'(req_ff.opcode);
      cmd = '0;
      cmd.task_id  = req_ff.task_id;
      cmd.delay    = req_ff.delay;
      cmd.periodic = req_ff.periodic;
      cmd.now      = clock_ff;
      tgt   = hit_idx_ff;
      do_op = 1'b0;
      if (apply) begin
         unique case (op)
            OP_REGISTER:   begin tgt = free_idx_ff; do_op = free_ok_ff; cmd.alloc = 1'b1; end
            OP_DEREGISTER: do_op = hit_ff;
            OP_SCHEDULE:   begin do_op = hit_ff; cmd.sched = 1'b1; end
            OP_RESCHEDULE: begin do_op = hit_ff; cmd.resched = 1'b1; end
            OP_UNSCHEDULE: begin do_op = hit_ff; cmd.unsched = 1'b1; end
            OP_SCAN: begin
               tgt = scan_idx;
               do_op = ring_valid_ff && stat[scan_idx].sched && stat[scan_idx].due;
               cmd.fire = 1'b1;
            end
            default: ;
         endcase
      end
      if (csr.valid) cmd.clear = 1'b1;
   end

   always_comb begin
      for (int i = 0; i < MAX_SLOTS; i++)
         sel[i] = do_op && (tgt == IW'(i)) &&
                  !(req_ff.opcode == OP_DEREGISTER);
   end

   // Deregister clears one slot: a per-cell clear in that cell's own command, not through sel.
   for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
      cell_cmd_type c;
      always_comb begin
         c = cmd;
         if (do_op && req_ff.opcode == OP_DEREGISTER && tgt == IW'(g)) c.clear = 1'b1;
      end
      tts_cell u_cell (
         .clock(clock), .reset(reset), .sel(sel[g]), .cmd(c),
         .match_id(req_ff.task_id), .match(match[g]), .stat(stat[g])
      );
   end

   always_comb begin
      unique case (state_ff)
         S_IDLE:  state_in = (req.valid && req.ready) ? S_EVAL : S_IDLE;
         S_EVAL:  state_in = S_APPLY;
         S_APPLY: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   logic fire_now;
   assign fire_now = apply && req_ff.opcode == OP_SCAN && do_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff <= CW'(MAX_SLOTS < 16 ? MAX_SLOTS : 16);
         clock_ff <= '0; runs_ff <= '0;
         ring_valid_ff <= 1'b0; cursor_valid_ff <= 1'b0;
         head_ff <= '0; tail_ff <= '0; cursor_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         if (csr.valid) begin
            if (csr.data == 5'd0 || 32'(csr.data) > 32'(MAX_SLOTS))
               active_ff <= CW'(MAX_SLOTS);
            else
               active_ff <= CW'(csr.data);
            ring_valid_ff <= 1'b0; cursor_valid_ff <= 1'b0;
            head_ff <= '0; tail_ff <= '0; cursor_ff <= '0;
         end
         if (req.valid && req.ready) req_ff <= req.data;
         if (state_ff == S_EVAL) begin
            hit_ff <= hit_in; hit_idx_ff <= hit_idx_in;
            free_ok_ff <= free_ok_in; free_idx_ff <= free_idx_in;
         end
         if (apply) begin
            rsp_valid_ff <= 1'b1;
            unique case (req_ff.opcode)
               OP_REGISTER: if (free_ok_ff) begin
                  if (ring_valid_ff) begin
                     prev_ff[free_idx_ff] <= tail_ff;
                     next_ff[free_idx_ff] <= head_ff;
                     next_ff[tail_ff] <= free_idx_ff;
                     prev_ff[head_ff] <= free_idx_ff;
                  end else begin
                     head_ff <= free_idx_ff;
                     next_ff[free_idx_ff] <= free_idx_ff;
                     prev_ff[free_idx_ff] <= free_idx_ff;
                     ring_valid_ff <= 1'b1;
                  end
                  tail_ff <= free_idx_ff;
               end
               OP_DEREGISTER: if (hit_ff) begin
                  if (next_ff[hit_idx_ff] == hit_idx_ff) begin
                     ring_valid_ff <= 1'b0; cursor_valid_ff <= 1'b0;
                     head_ff <= '0; tail_ff <= '0; cursor_ff <= '0;
                  end else begin
                     next_ff[prev_ff[hit_idx_ff]] <= next_ff[hit_idx_ff];
                     prev_ff[next_ff[hit_idx_ff]] <= prev_ff[hit_idx_ff];
                     if (head_ff == hit_idx_ff) head_ff <= next_ff[hit_idx_ff];
                     if (tail_ff == hit_idx_ff) tail_ff <= prev_ff[hit_idx_ff];
                     if (cursor_valid_ff && cursor_ff == hit_idx_ff)
                        cursor_ff <= next_ff[hit_idx_ff];
                  end
               end
               OP_TICK: clock_ff <= clock_ff + 32'd1;
               OP_SCAN: if (ring_valid_ff) begin
                  cursor_ff <= next_ff[scan_idx];
                  cursor_valid_ff <= 1'b1;
                  if (fire_now) runs_ff <= runs_ff + 32'd1;
               end
               default: ;
            endcase
         end
      end
   end

   // Response payload; clock and run count shown after the step.
   always_ff @(posedge clock) begin
      if (apply) begin
         rsp_ff.fired     <= fire_now;
         rsp_ff.fired_id  <= fire_now ? stat[scan_idx].task_id : 16'd0;
         rsp_ff.clock_now <= (req_ff.opcode == OP_TICK) ? clock_ff + 32'd1 : clock_ff;
         rsp_ff.run_total <= fire_now ? runs_ff + 32'd1 : runs_ff;
         unique case (req_ff.opcode) inside
            OP_REGISTER: rsp_ff.status <= free_ok_ff ? ST_OK : ST_NOFREE;
            OP_DEREGISTER, OP_SCHEDULE, OP_RESCHEDULE, OP_UNSCHEDULE:
               rsp_ff.status <= hit_ff ? ST_OK : ST_NOTFOUND;
            OP_SCAN: rsp_ff.status <= ring_valid_ff ? ST_OK : ST_EMPTY;
            default: rsp_ff.status <= ST_OK;
         endcase
      end
   end

   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("ready while busy");
   a_rsp_after_apply: assert property (@(posedge clock) disable iff (reset)
      apply |=> rsp_valid_ff) else $error("no response after apply");
   a_fire_counts: assert property (@(posedge clock) disable iff (reset || csr.valid)
      fire_now |=> runs_ff == $past(runs_ff) + 32'd1) else $error("run count");
   a_sel_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(sel)) else $error("multiple cells selected");
endmodule

[verif/tb_task_timer_scheduler.sv]
// Self-checking testbench for the task timer scheduler.
module tb_task_timer_scheduler;
   import tts_pkg::*;

   // Slot flag bits of the shadow table; the scheduler keeps each as its own flop.
   localparam logic [2:0] FL_SCHED    = 3'b001;
   localparam logic [2:0] FL_PERIODIC = 3'b010;
   localparam logic [2:0] FL_ALLOC    = 3'b100;
   localparam int NSLOT = 16;
   localparam int SETTLE_CYCLES = 8;        // covers a request's pass through decode, apply and respond

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #2 clock = ~clock;

   tts_req_if req_if ();
   tts_rsp_if rsp_if ();
   tts_csr_if csr_if ();

   task_timer_scheduler #(.MAX_SLOTS(NSLOT)) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if),
      .csr  (csr_if)
   );

   // ---------------------------------------------------------------------
   // Scheduler shadow: table, ring, clock and run count
   // ---------------------------------------------------------------------
   int          sh_active;
   logic [15:0] sh_id[NSLOT];
   logic [31:0] sh_deadline[NSLOT];
   logic [31:0] sh_delay[NSLOT];
   logic [2:0]  sh_flags[NSLOT];
   int          sh_next[NSLOT];
   int          sh_prev[NSLOT];
   int          sh_head, sh_tail, sh_cursor;
   bit          sh_ring_ok, sh_cursor_ok;
   logic [31:0] sh_clock, sh_runs;

   rsp_type pending_rsp[$];     // responses still owed by the block
   int      mismatches = 0;
   int      n_fired = 0;
   int      n_status[4];
   int      n_requests = 0;

   function automatic void wipe_table();
      for (int i = 0; i < NSLOT; i++) begin
         sh_id[i] = '0; sh_deadline[i] = '0; sh_delay[i] = '0; sh_flags[i] = '0;
         sh_next[i] = 0; sh_prev[i] = 0;
      end
      sh_head = 0; sh_tail = 0; sh_cursor = 0;
      sh_ring_ok = 0; sh_cursor_ok = 0;
   endfunction

   // Zero or anything above the table size means a full table.
   function automatic void apply_active_slots(logic [4:0] v);
      sh_active = (v == 0 || v > NSLOT) ? NSLOT : int'(v);
      wipe_table();
   endfunction

   function automatic int lookup_slot(logic [15:0] id);
      for (int i = 0; i < sh_active; i++)
         if ((sh_flags[i] & FL_ALLOC) != 0 && sh_id[i] == id) return i;
      return -1;
   endfunction

   function automatic status_type add_task(logic [15:0] id);
      for (int i = 0; i < sh_active; i++) begin
         if ((sh_flags[i] & FL_ALLOC) == 0) begin
            sh_id[i] = id; sh_deadline[i] = '0; sh_delay[i] = '0;
            sh_flags[i] = FL_ALLOC;
            if (sh_ring_ok) begin
               // append behind the tail, close the ring onto the head
               sh_prev[i] = sh_tail;
               sh_next[i] = sh_head;
               sh_next[sh_tail] = i;
               sh_prev[sh_head] = i;
               sh_tail = i;
            end else begin
               sh_head = i; sh_tail = i;
               sh_next[i] = i; sh_prev[i] = i;
               sh_ring_ok = 1;
            end
            return ST_OK;
         end
      end
      return ST_NOFREE;
   endfunction

   function automatic void drop_task(int s);
      int nx, pv;
      nx = sh_next[s];
      pv = sh_prev[s];
      if (nx == s) begin
         // last task gone: ring and cursor empty
         sh_ring_ok = 0; sh_cursor_ok = 0;
         sh_head = 0; sh_tail = 0; sh_cursor = 0;
      end else begin
         sh_next[pv] = nx;
         sh_prev[nx] = pv;
         if (sh_head == s) sh_head = nx;
         if (sh_tail == s) sh_tail = pv;
         if (sh_cursor_ok && sh_cursor == s) sh_cursor = nx;
      end
      sh_id[s] = '0; sh_deadline[s] = '0; sh_delay[s] = '0; sh_flags[s] = '0;
   endfunction

   // One request in, the response it must produce out; shadow state updated.
   function automatic rsp_type run_request(req_type r);
      rsp_type o;
      int s;
      o = '0;
      o.status = ST_OK;
      case (opcode_type'(r.opcode))
         OP_REGISTER: o.status = add_task(r.task_id);
         OP_DEREGISTER, OP_SCHEDULE, OP_RESCHEDULE, OP_UNSCHEDULE: begin
            s = lookup_slot(r.task_id);
            if (s < 0) o.status = ST_NOTFOUND;
            else case (opcode_type'(r.opcode))
               OP_DEREGISTER: drop_task(s);
               OP_SCHEDULE: begin
                  sh_delay[s] = r.delay;
                  sh_deadline[s] = sh_clock + r.delay;
                  sh_flags[s] = FL_ALLOC | FL_SCHED | (r.periodic ? FL_PERIODIC : 3'b000);
               end
               OP_RESCHEDULE: begin
                  sh_deadline[s] = sh_clock + sh_delay[s];
                  sh_flags[s] = sh_flags[s] | FL_SCHED;
               end
               default: begin
                  sh_deadline[s] = '0;
                  sh_flags[s] = sh_flags[s] & ~FL_SCHED;
               end
            endcase
         end
         OP_TICK: sh_clock = sh_clock + 1;
         OP_SCAN: begin
            if (!sh_ring_ok) o.status = ST_EMPTY;
            else begin
               s = sh_cursor_ok ? sh_cursor : sh_head;
               // due compare is unsigned, deadline may have wrapped
               if ((sh_flags[s] & FL_SCHED) != 0 && sh_clock >= sh_deadline[s]) begin
                  o.fired = 1'b1;
                  o.fired_id = sh_id[s];
                  sh_flags[s] = sh_flags[s] & ~FL_SCHED;
                  if ((sh_flags[s] & FL_PERIODIC) != 0) begin
                     sh_deadline[s] = sh_clock + sh_delay[s];
                     sh_flags[s] = sh_flags[s] | FL_SCHED;
                  end
                  sh_runs = sh_runs + 1;
               end
               sh_cursor = sh_next[s];
               sh_cursor_ok = 1;
            end
         end
         default: ;  // no-op
      endcase
      o.clock_now = sh_clock;
      o.run_total = sh_runs;
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Response checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", 32'(rsp_if.data.status), 32'd0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_if.data.fired !== want.fired)
               report_mismatch("fired", 32'(rsp_if.data.fired), 32'(want.fired));
            if (rsp_if.data.fired_id !== want.fired_id)
               report_mismatch("fired_id", 32'(rsp_if.data.fired_id), 32'(want.fired_id));
            if (rsp_if.data.status !== want.status)
               report_mismatch("status", 32'(rsp_if.data.status), 32'(want.status));
            if (rsp_if.data.clock_now !== want.clock_now)
               report_mismatch("clock_now", rsp_if.data.clock_now, want.clock_now);
            if (rsp_if.data.run_total !== want.run_total)
               report_mismatch("run_total", rsp_if.data.run_total, want.run_total);
         end
      end
   end

   // Mostly no wait, sometimes a few cycles, rarely a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Response stalls; some stretches keep ready high throughout.
   initial begin
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 3) == 0) begin
            rsp_if.ready = 1'b1;
            repeat ($urandom_range(20, 80)) @(negedge clock);
         end
         rsp_if.ready = 1'b0;
         repeat (pick_gap()) @(negedge clock);
         rsp_if.ready = 1'b1;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Request and csr drivers (drive on falling edge, accept on rising)
   // ---------------------------------------------------------------------
   // Caller sits just after a falling edge. Returns there after the accept.
   task automatic send_request(req_type r, bit typed, rsp_type typed_rsp);
      rsp_type got;
      req_if.valid = 1'b1;
      req_if.data = r;
      do @(posedge clock); while (!req_if.ready);
      got = run_request(r);
      pending_rsp.push_back(typed ? typed_rsp : got);
      n_requests++;
      n_status[got.status]++;
      if (got.fired) n_fired++;
      @(negedge clock);
      if (pick_gap() != 0) begin
         req_if.valid = 1'b0;
         repeat (pick_gap()) @(negedge clock);
      end
   endtask

   task automatic drain_responses();
      req_if.valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // Table is rewritten only with nothing in flight.
   task automatic write_active_slots(logic [4:0] v);
      drain_responses();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.data = v;
      do @(posedge clock); while (!csr_if.ready);
      apply_active_slots(v);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // Directed table: typed responses only where obvious.
   typedef struct {
      opcode_type  op;
      logic [15:0] id;
      logic [31:0] dly;
      logic        per;
      bit          typed;
      rsp_type     want;
   } directed_row_type;

   directed_row_type directed_rows[$] = '{
      '{OP_SCAN,       16'h0000, 32'h0, 1'b0, 1, '{1'b0, 16'h0, ST_EMPTY,    32'd0, 32'd0}},
      '{OP_DEREGISTER, 16'h0000, 32'h0, 1'b0, 1, '{1'b0, 16'h0, ST_NOTFOUND, 32'd0, 32'd0}},
      '{OP_NOP,        16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1, '{1'b0, 16'h0, ST_OK, 32'd0, 32'd0}},
      '{OP_TICK,       16'h0000, 32'h0, 1'b0, 1, '{1'b0, 16'h0, ST_OK,       32'd1, 32'd0}},
      '{OP_REGISTER,   16'hFFFF, 32'h0, 1'b0, 0, '{default:'0}},
      '{OP_REGISTER,   16'h0000, 32'h0, 1'b0, 0, '{default:'0}},
      '{OP_REGISTER,   16'hFFFF, 32'h0, 1'b0, 0, '{default:'0}},  // duplicate ID
      '{OP_SCHEDULE,   16'hFFFF, 32'h0, 1'b1, 0, '{default:'0}},  // due at once, periodic
      '{OP_SCAN,       16'h0000, 32'h0, 1'b0, 0, '{default:'0}},
      '{OP_SCAN,       16'h0000, 32'h0, 1'b0, 0, '{default:'0}},
      '{OP_SCAN,       16'h0000, 32'h0, 1'b0, 0, '{default:'0}},
      '{OP_SCAN,       16'h0000, 32'h0, 1'b0, 0, '{default:'0}},  // wraps to head, fires again
      '{OP_SCHEDULE,   16'h0000, 32'hFFFF_FFFF, 1'b0, 0, '{default:'0}},  // deadline wraps
      '{OP_TICK,       16'h0000, 32'h0, 1'b0, 0, '{default:'0}},
      '{OP_RESCHEDULE, 16'hFFFF, 32'h0, 1'b0, 0, '{default:'0}},
      '{OP_UNSCHEDULE, 16'hFFFF, 32'h0, 1'b0, 0, '{default:'0}},
      '{OP_SCAN,       16'h0000, 32'h0, 1'b0, 0, '{default:'0}},
      '{OP_DEREGISTER, 16'h0000, 32'h0, 1'b0, 0, '{default:'0}},  // unlink the middle task
      '{OP_SCHEDULE,   16'h0000, 32'h5, 1'b0, 0, '{default:'0}},
      '{OP_RESCHEDULE, 16'h1234, 32'h0, 1'b0, 0, '{default:'0}},
      '{OP_UNSCHEDULE, 16'h1234, 32'h0, 1'b0, 0, '{default:'0}},
      '{OP_DEREGISTER, 16'hFFFF, 32'h0, 1'b0, 0, '{default:'0}},
      '{OP_DEREGISTER, 16'hFFFF, 32'h0, 1'b0, 0, '{default:'0}},  // ring empties
      '{OP_SCAN,       16'h0000, 32'h0, 1'b0, 0, '{default:'0}}
   };

   // Well-formed traffic on a small ID pool; a slice of noise on top.
   function automatic req_type random_request();
      req_type r;
      int w;
      r.task_id = 16'($urandom_range(0, 5)) | ($urandom_range(0, 1) ? 16'hA500 : 16'h0);
      r.delay = $urandom_range(0, 6);
      r.periodic = 1'($urandom_range(0, 1));
      w = $urandom_range(0, 99);
      if      (w < 14) r.opcode = OP_REGISTER;
      else if (w < 22) r.opcode = OP_DEREGISTER;
      else if (w < 40) r.opcode = OP_SCHEDULE;
      else if (w < 47) r.opcode = OP_RESCHEDULE;
      else if (w < 52) r.opcode = OP_UNSCHEDULE;
      else if (w < 72) r.opcode = OP_TICK;
      else if (w < 97) r.opcode = OP_SCAN;
      else             r.opcode = OP_NOP;
      // noise: any ID, any delay, including ones that wrap the deadline
      if ($urandom_range(0, 9) == 0) r.task_id = 16'($urandom());
      if ($urandom_range(0, 14) == 0) r.delay = $urandom();
      if ($urandom_range(0, 29) == 0) r.delay = 32'hFFFF_FFFF - $urandom_range(0, 3);
      return r;
   endfunction

   logic [4:0] phase_slots[] = '{5'd2, 5'd1, 5'd31, 5'd0, 5'd7, 5'd16};
   bit stimulus_done = 0;

   initial begin
      req_type r;
      req_if.valid = 1'b0;
      req_if.data = '0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      apply_active_slots(5'd16);
      sh_clock = '0;
      sh_runs = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part on the reset table size
      foreach (directed_rows[k]) begin
         r.opcode = directed_rows[k].op;
         r.task_id = directed_rows[k].id;
         r.delay = directed_rows[k].dly;
         r.periodic = directed_rows[k].per;
         send_request(r, directed_rows[k].typed, directed_rows[k].want);
      end

      // random phases, each on a fresh table size
      foreach (phase_slots[p]) begin
         write_active_slots(phase_slots[p]);
         for (int n = 0; n < 205; n++) begin
            // hold the sender once until the block is fully drained
            if (p == 2 && n == 100) drain_responses();
            send_request(random_request(), 0, '0);
         end
      end
      req_if.valid = 1'b0;
      stimulus_done = 1;
   end

   // ---------------------------------------------------------------------
   // End of run
   // ---------------------------------------------------------------------
   initial begin
      wait (stimulus_done);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d requests over %0d table sizes, %0d tasks fired.",
               n_requests, phase_slots.size() + 1, n_fired);
      $display("Status mix: ok %0d, no free slot %0d, not found %0d, empty %0d.",
               n_status[0], n_status[1], n_status[2], n_status[3]);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout with %0d responses outstanding", pending_rsp.size());
      $display("FAILED: results differ");
      $finish;
   end
endmodule
